FILE: design/erm_pkg.sv
// Shared types, widths and series coefficients for the Euler rotation matrix block.
// No dependencies; used by euler_rotation_matrix.
`default_nettype none

package erm_pkg;

    localparam int ANGLE_BITS = 16;
    localparam int FRAC_BITS  = 14;
    localparam int LANES      = 3;
    localparam int QTR_BITS   = ANGLE_BITS - 2;
    localparam int OCT_BITS   = ANGLE_BITS - 3;
    localparam int U_BITS     = QTR_BITS;
    localparam int PQ         = 30;
    localparam int P_W        = 32;
    localparam int V2_W       = PQ + 1;
    localparam int V2_SH      = PQ - 2 * OCT_BITS;
    localparam int HORNER     = 5;
    localparam int ENT_W      = FRAC_BITS + 2;
    localparam int ENTRIES    = 9;

    typedef logic [ANGLE_BITS-1:0]   angle_t;
    typedef logic signed [ENT_W-1:0] entry_t;

    typedef struct packed {
        angle_t angle_x;
        angle_t angle_y;
        angle_t angle_z;
    } in_t;

    typedef struct packed {
        entry_t r00;
        entry_t r01;
        entry_t r02;
        entry_t r10;
        entry_t r11;
        entry_t r12;
        entry_t r20;
        entry_t r21;
        entry_t r22;
    } out_t;

    // sin(pi/4 * v) = sum of SIN[k] * v^(2k+1), alternating signs, Q2.30 magnitudes
    function automatic logic signed [P_W-1:0] sin_coef(input int k);
        logic signed [P_W-1:0] c;
        unique case (k)
            0:       c = 32'sd843314857;
            1:       c = 32'sd86699834;
            2:       c = 32'sd2674056;
            3:       c = 32'sd39273;
            default: c = 32'sd336;
        endcase
        return c;
    endfunction

    // cos(pi/4 * v) = sum of COS[k] * v^(2k), alternating signs, Q2.30 magnitudes
    function automatic logic signed [P_W-1:0] cos_coef(input int k);
        logic signed [P_W-1:0] c;
        unique case (k)
            0:       c = 32'sd1073741824;
            1:       c = 32'sd331168970;
            2:       c = 32'sd17023568;
            3:       c = 32'sd350033;
            4:       c = 32'sd3856;
            default: c = 32'sd26;
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

FILE: design/euler_rotation_matrix.sv
// Rotation matrix Rx*Ry*Rz from three binary angles, fully pipelined.
// Depends on erm_pkg for word types, widths and series coefficients.
//
// Takes one angle word per cycle and returns the nine Q1.14 entries; a word can
// enter every cycle while m_ready stays high. The pipeline contains the five-step
// polynomial evaluation of sine and cosine (one multiply per stage) and the
// three stages that form, sum and round the matrix products.
// m_ready low while a result is waiting holds the whole pipe in place.
`default_nettype none

module euler_rotation_matrix (
    input  wire              aclk,
    input  wire              aresetn,
    input  wire              s_valid,
    output logic             s_ready,
    input  erm_pkg::in_t     s_word,
    output logic             m_valid,
    input  wire              m_ready,
    output erm_pkg::out_t    m_word
);

    localparam int NVLD  = 9;
    localparam int PW2   = 2 * erm_pkg::ENT_W - 1;
    localparam int TW    = 46;
    localparam int SW    = TW + 1;
    localparam int SH    = 2 * erm_pkg::FRAC_BITS;
    localparam int OUT_W = SW - SH;
    localparam logic [erm_pkg::U_BITS:0] QTR = (erm_pkg::U_BITS+1)'(1 << erm_pkg::QTR_BITS);
    localparam logic signed [erm_pkg::P_W-1:0] RHALF =
        erm_pkg::P_W'(1 << (erm_pkg::PQ - erm_pkg::FRAC_BITS - 1));
    localparam logic signed [SW-1:0] EHALF = SW'(1) <<< (SH - 1);
    localparam logic signed [OUT_W-1:0] ONE_P = OUT_W'(1 << erm_pkg::FRAC_BITS);
    localparam logic signed [OUT_W-1:0] ONE_N = -ONE_P;

    function automatic logic signed [erm_pkg::P_W-1:0] mulq(
        input logic signed [erm_pkg::P_W-1:0] p,
        input logic [erm_pkg::V2_W-1:0]       v2
    );
        logic signed [2*erm_pkg::P_W-1:0] prod;
        prod = (2*erm_pkg::P_W)'(p) * (2*erm_pkg::P_W)'(signed'({1'b0, v2}));
        return prod[erm_pkg::PQ+erm_pkg::P_W-1:erm_pkg::PQ];
    endfunction

    logic                                 adv;
    logic [NVLD-1:0]                      vld_reg;
    logic                                 out_valid_reg;
    erm_pkg::out_t                        out_reg;

    erm_pkg::angle_t                      ang [0:erm_pkg::LANES-1];
    logic [erm_pkg::U_BITS-1:0]           u_next [0:erm_pkg::LANES-1];
    logic [erm_pkg::V2_W-1:0]             v2_next [0:erm_pkg::LANES-1];
    logic                                 swap_next [0:erm_pkg::LANES-1];

    logic [erm_pkg::U_BITS-1:0]           u_reg [0:erm_pkg::HORNER][0:erm_pkg::LANES-1];
    logic [erm_pkg::V2_W-1:0]             v2_reg [0:erm_pkg::HORNER][0:erm_pkg::LANES-1];
    logic [1:0]                           quad_reg [0:erm_pkg::HORNER][0:erm_pkg::LANES-1];
    logic                                 swap_reg [0:erm_pkg::HORNER][0:erm_pkg::LANES-1];
    logic signed [erm_pkg::P_W-1:0]       ps_reg [0:erm_pkg::HORNER][0:erm_pkg::LANES-1];
    logic signed [erm_pkg::P_W-1:0]       pc_reg [0:erm_pkg::HORNER][0:erm_pkg::LANES-1];

    erm_pkg::entry_t                      sn_next [0:erm_pkg::LANES-1];
    erm_pkg::entry_t                      cs_next [0:erm_pkg::LANES-1];
    erm_pkg::entry_t                      sn_reg [0:erm_pkg::LANES-1];
    erm_pkg::entry_t                      cs_reg [0:erm_pkg::LANES-1];

    logic signed [PW2-1:0]                p_cycz_reg, p_cysz_reg, p_sxcy_reg, p_cxcy_reg;
    logic signed [PW2-1:0]                p_cxcz_reg, p_sxsz_reg, p_sxcz_reg, p_cxsz_reg;
    logic signed [PW2-1:0]                p_sxsy_reg, p_cxsy_reg;
    erm_pkg::entry_t                      sy2_reg, sz2_reg, cz2_reg;

    logic signed [TW-1:0]                 ta_reg [0:erm_pkg::ENTRIES-1];
    logic signed [TW-1:0]                 tb_reg [0:erm_pkg::ENTRIES-1];
    erm_pkg::entry_t                      ent_next [0:erm_pkg::ENTRIES-1];

    assign adv     = !out_valid_reg || m_ready;
    assign s_ready = adv;
    assign m_valid = out_valid_reg;
    assign m_word  = out_reg;

    assign ang[0] = s_word.angle_x;
    assign ang[1] = s_word.angle_y;
    assign ang[2] = s_word.angle_z;

    // fold each angle into the first octant
    always_comb begin
        logic [erm_pkg::QTR_BITS-1:0] r;
        logic [erm_pkg::U_BITS:0]     diff;
        logic [2*erm_pkg::U_BITS-1:0] uu;
        for (int a = 0; a < erm_pkg::LANES; a++) begin
            r            = ang[a][erm_pkg::QTR_BITS-1:0];
            swap_next[a] = r[erm_pkg::QTR_BITS-1] && (r[erm_pkg::QTR_BITS-2:0] != '0);
            diff         = QTR - {1'b0, r};
            u_next[a]    = swap_next[a] ? diff[erm_pkg::U_BITS-1:0] : r;
            uu           = (2*erm_pkg::U_BITS)'(u_next[a]) * (2*erm_pkg::U_BITS)'(u_next[a]);
            v2_next[a]   = erm_pkg::V2_W'(uu) << erm_pkg::V2_SH;
        end
    end

    // round, undo the octant fold, apply quadrant signs
    always_comb begin
        logic signed [erm_pkg::P_W-1:0] rs, rc;
        erm_pkg::entry_t s0, c0, st, ct;
        for (int a = 0; a < erm_pkg::LANES; a++) begin
            rs = ps_reg[erm_pkg::HORNER][a] + RHALF;
            rc = pc_reg[erm_pkg::HORNER][a] + RHALF;
            s0 = erm_pkg::ENT_W'({1'b0, rs[erm_pkg::PQ:erm_pkg::PQ-erm_pkg::FRAC_BITS]});
            c0 = erm_pkg::ENT_W'({1'b0, rc[erm_pkg::PQ:erm_pkg::PQ-erm_pkg::FRAC_BITS]});
            st = swap_reg[erm_pkg::HORNER][a] ? c0 : s0;
            ct = swap_reg[erm_pkg::HORNER][a] ? s0 : c0;
            unique case (quad_reg[erm_pkg::HORNER][a])
                2'd0: begin
                    sn_next[a] = st;
                    cs_next[a] = ct;
                end
                2'd1: begin
                    sn_next[a] = ct;
                    cs_next[a] = -st;
                end
                2'd2: begin
                    sn_next[a] = -st;
                    cs_next[a] = -ct;
                end
                default: begin
                    sn_next[a] = -ct;
                    cs_next[a] = st;
                end
            endcase
        end
    end

    // sum, round once and clamp each entry
    always_comb begin
        logic signed [SW-1:0]    w;
        logic signed [OUT_W-1:0] v;
        for (int e = 0; e < erm_pkg::ENTRIES; e++) begin
            w = SW'(ta_reg[e]) + SW'(tb_reg[e]) + EHALF;
            v = w[SW-1:SH];
            if (v > ONE_P) begin
                ent_next[e] = erm_pkg::ENT_W'(ONE_P);
            end else if (v < ONE_N) begin
                ent_next[e] = erm_pkg::ENT_W'(ONE_N);
            end else begin
                ent_next[e] = erm_pkg::ENT_W'(v);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else if (adv) begin
            vld_reg       <= {vld_reg[NVLD-2:0], s_valid};
            out_valid_reg <= vld_reg[NVLD-1];
        end
    end

    always_ff @(posedge aclk) begin
        logic signed [erm_pkg::P_W+erm_pkg::U_BITS:0] sp;
        if (adv) begin
            for (int a = 0; a < erm_pkg::LANES; a++) begin
                u_reg[0][a]    <= u_next[a];
                v2_reg[0][a]   <= v2_next[a];
                quad_reg[0][a] <= ang[a][erm_pkg::ANGLE_BITS-1:erm_pkg::QTR_BITS];
                swap_reg[0][a] <= swap_next[a];
                ps_reg[0][a]   <= erm_pkg::sin_coef(4);
                pc_reg[0][a]   <= erm_pkg::cos_coef(5);
                for (int j = 1; j <= erm_pkg::HORNER; j++) begin
                    u_reg[j][a]    <= u_reg[j-1][a];
                    v2_reg[j][a]   <= v2_reg[j-1][a];
                    quad_reg[j][a] <= quad_reg[j-1][a];
                    swap_reg[j][a] <= swap_reg[j-1][a];
                    pc_reg[j][a]   <= erm_pkg::cos_coef(erm_pkg::HORNER - j)
                                      - mulq(pc_reg[j-1][a], v2_reg[j-1][a]);
                end
                for (int j = 1; j < erm_pkg::HORNER; j++) begin
                    ps_reg[j][a] <= erm_pkg::sin_coef(erm_pkg::HORNER - 1 - j)
                                    - mulq(ps_reg[j-1][a], v2_reg[j-1][a]);
                end
                sp = (erm_pkg::P_W+erm_pkg::U_BITS+1)'(ps_reg[erm_pkg::HORNER-1][a])
                     * (erm_pkg::P_W+erm_pkg::U_BITS+1)'(
                         signed'({1'b0, u_reg[erm_pkg::HORNER-1][a]}));
                ps_reg[erm_pkg::HORNER][a] <=
                    sp[erm_pkg::OCT_BITS+erm_pkg::P_W-1:erm_pkg::OCT_BITS];
                sn_reg[a] <= sn_next[a];
                cs_reg[a] <= cs_next[a];
            end

            p_cycz_reg <= PW2'(cs_reg[1]) * PW2'(cs_reg[2]);
            p_cysz_reg <= PW2'(cs_reg[1]) * PW2'(sn_reg[2]);
            p_sxcy_reg <= PW2'(sn_reg[0]) * PW2'(cs_reg[1]);
            p_cxcy_reg <= PW2'(cs_reg[0]) * PW2'(cs_reg[1]);
            p_cxcz_reg <= PW2'(cs_reg[0]) * PW2'(cs_reg[2]);
            p_sxsz_reg <= PW2'(sn_reg[0]) * PW2'(sn_reg[2]);
            p_sxcz_reg <= PW2'(sn_reg[0]) * PW2'(cs_reg[2]);
            p_cxsz_reg <= PW2'(cs_reg[0]) * PW2'(sn_reg[2]);
            p_sxsy_reg <= PW2'(sn_reg[0]) * PW2'(sn_reg[1]);
            p_cxsy_reg <= PW2'(cs_reg[0]) * PW2'(sn_reg[1]);
            sy2_reg    <= sn_reg[1];
            sz2_reg    <= sn_reg[2];
            cz2_reg    <= cs_reg[2];

            ta_reg[0] <= TW'(p_cycz_reg) <<< erm_pkg::FRAC_BITS;
            tb_reg[0] <= '0;
            ta_reg[1] <= -(TW'(p_cysz_reg) <<< erm_pkg::FRAC_BITS);
            tb_reg[1] <= '0;
            ta_reg[2] <= TW'(sy2_reg) <<< SH;
            tb_reg[2] <= '0;
            ta_reg[3] <= TW'(p_sxsy_reg) * TW'(cz2_reg);
            tb_reg[3] <= TW'(p_cxsz_reg) <<< erm_pkg::FRAC_BITS;
            ta_reg[4] <= TW'(p_cxcz_reg) <<< erm_pkg::FRAC_BITS;
            tb_reg[4] <= -(TW'(p_sxsy_reg) * TW'(sz2_reg));
            ta_reg[5] <= -(TW'(p_sxcy_reg) <<< erm_pkg::FRAC_BITS);
            tb_reg[5] <= '0;
            ta_reg[6] <= TW'(p_sxsz_reg) <<< erm_pkg::FRAC_BITS;
            tb_reg[6] <= -(TW'(p_cxsy_reg) * TW'(cz2_reg));
            ta_reg[7] <= TW'(p_cxsy_reg) * TW'(sz2_reg);
            tb_reg[7] <= TW'(p_sxcz_reg) <<< erm_pkg::FRAC_BITS;
            ta_reg[8] <= TW'(p_cxcy_reg) <<< erm_pkg::FRAC_BITS;
            tb_reg[8] <= '0;

            out_reg.r00 <= ent_next[0];
            out_reg.r01 <= ent_next[1];
            out_reg.r02 <= ent_next[2];
            out_reg.r10 <= ent_next[3];
            out_reg.r11 <= ent_next[4];
            out_reg.r12 <= ent_next[5];
            out_reg.r20 <= ent_next[6];
            out_reg.r21 <= ent_next[7];
            out_reg.r22 <= ent_next[8];
        end
    end

endmodule

`default_nettype wire

FILE: verif/euler_rotation_matrix_tb.sv
// Self-checking testbench for euler_rotation_matrix: directed and random angle words,
// random idling on both channels, scoreboard with a bit-exact rotation predictor.
// Depends on erm_pkg and the euler_rotation_matrix RTL.
`timescale 1ns / 100ps

module euler_rotation_matrix_tb;

    localparam longint unsigned Q62_ONE    = 64'h4000000000000000;
    localparam longint unsigned Q62_HALFPI = 64'h6487ED5110B4611A;
    localparam longint          ONE_Q      = 64'sd1 << erm_pkg::FRAC_BITS;

    function automatic longint unsigned mul_q62(longint unsigned a, longint unsigned b);
        logic [127:0] p;
        p = {64'd0, a} * {64'd0, b};
        return p[125:62];
    endfunction

    function automatic longint round_q(longint unsigned v);
        return longint'((v + (64'd1 << (61 - erm_pkg::FRAC_BITS))) >> (62 - erm_pkg::FRAC_BITS));
    endfunction

    function automatic void sine_cosine(input erm_pkg::angle_t ang, output longint s,
                                        output longint c);
        longint unsigned quarter, r, u, x, x2, ps, pc, n;
        logic [1:0] q;
        logic swap;
        longint s0, c0, t;
        quarter = 64'd1 << (erm_pkg::ANGLE_BITS - 2);
        r = ang & (quarter - 1);
        q = ang[erm_pkg::ANGLE_BITS-1 -: 2];
        swap = r > quarter - r;
        u = swap ? quarter - r : r;
        x = mul_q62(Q62_HALFPI, u << (64 - erm_pkg::ANGLE_BITS));
        x2 = mul_q62(x, x);
        ps = Q62_ONE;
        pc = Q62_ONE;
        for (n = 20; n >= 2; n -= 2)
            ps = Q62_ONE - mul_q62(x2, ps) / (n * (n + 1));
        for (n = 19; n >= 1; n -= 2) begin
            pc = Q62_ONE - mul_q62(x2, pc) / (n * (n + 1));
            if (n == 1) break;
        end
        s0 = round_q(mul_q62(x, ps));
        c0 = round_q(pc);
        if (swap) begin
            t = s0; s0 = c0; c0 = t;
        end
        case (q)
            2'd0: begin s = s0;  c = c0;  end
            2'd1: begin s = c0;  c = -s0; end
            2'd2: begin s = -s0; c = -c0; end
            default: begin s = -c0; c = s0; end
        endcase
    endfunction

    function automatic erm_pkg::entry_t round_entry(longint w);
        longint v;
        v = (w + (64'sd1 << (2 * erm_pkg::FRAC_BITS - 1))) >>> (2 * erm_pkg::FRAC_BITS);
        if (v > ONE_Q) v = ONE_Q;
        if (v < -ONE_Q) v = -ONE_Q;
        return erm_pkg::entry_t'(v[erm_pkg::ENT_W-1:0]);
    endfunction

    function automatic erm_pkg::out_t rotation_of(erm_pkg::in_t w);
        longint sx, cx, sy, cy, sz, cz;
        erm_pkg::out_t m;
        sine_cosine(w.angle_x, sx, cx);
        sine_cosine(w.angle_y, sy, cy);
        sine_cosine(w.angle_z, sz, cz);
        m.r00 = round_entry(cy * cz * ONE_Q);
        m.r01 = round_entry(-(cy * sz * ONE_Q));
        m.r02 = round_entry(sy * ONE_Q * ONE_Q);
        m.r10 = round_entry(sx * sy * cz + cx * sz * ONE_Q);
        m.r11 = round_entry(cx * cz * ONE_Q - sx * sy * sz);
        m.r12 = round_entry(-(sx * cy * ONE_Q));
        m.r20 = round_entry(sx * sz * ONE_Q - cx * sy * cz);
        m.r21 = round_entry(cx * sy * sz + sx * cz * ONE_Q);
        m.r22 = round_entry(cx * cy * ONE_Q);
        return m;
    endfunction

    class matrix_scoreboard;
        erm_pkg::out_t expected_q[$];
        int            errors;

        function new();
            errors = 0;
        endfunction

        function void note_angles(erm_pkg::in_t w);
            expected_q.push_back(rotation_of(w));
        endfunction

        function void cmp(string name, erm_pkg::entry_t e, erm_pkg::entry_t a);
            if (e !== a) begin
                $error("%s: expected %0d, got %0d", name, e, a);
                errors++;
            end
        endfunction

        function void check_matrix(erm_pkg::out_t got);
            erm_pkg::out_t e;
            if (expected_q.size() == 0) begin
                $error("unexpected result word %h", got);
                errors++;
                return;
            end
            e = expected_q.pop_front();
            cmp("r00", e.r00, got.r00);
            cmp("r01", e.r01, got.r01);
            cmp("r02", e.r02, got.r02);
            cmp("r10", e.r10, got.r10);
            cmp("r11", e.r11, got.r11);
            cmp("r12", e.r12, got.r12);
            cmp("r20", e.r20, got.r20);
            cmp("r21", e.r21, got.r21);
            cmp("r22", e.r22, got.r22);
        endfunction
    endclass

    logic           aclk;
    logic           aresetn;
    logic           s_valid;
    logic           s_ready;
    erm_pkg::in_t   s_word;
    logic           m_valid;
    logic           m_ready;
    erm_pkg::out_t  m_word;
    bit             no_idle;

    matrix_scoreboard sb = new();

    euler_rotation_matrix dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_word  (s_word),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_word  (m_word)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            m_ready <= no_idle || ($urandom_range(99) >= 38);
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            sb.check_matrix(m_word);
        end
    end

    // drive one word; called at a falling edge, returns at a falling edge
    task automatic send_angles(input erm_pkg::in_t w);
        while (!no_idle && $urandom_range(99) < 38) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_word  <= w;
        forever begin
            @(posedge aclk);
            if (s_ready) break;
        end
        sb.note_angles(w);
        @(negedge aclk);
    endtask

    function automatic erm_pkg::angle_t pick_angle();
        erm_pkg::angle_t a;
        case ($urandom_range(3))
            0: a = erm_pkg::angle_t'($urandom_range(3) << (erm_pkg::ANGLE_BITS - 2))
                   + erm_pkg::angle_t'($urandom_range(4)) - erm_pkg::angle_t'(2);
            1: a = erm_pkg::angle_t'(($urandom_range(7) << (erm_pkg::ANGLE_BITS - 3))
                   + $urandom_range(2)) - erm_pkg::angle_t'(1);
            default: a = erm_pkg::angle_t'($urandom);
        endcase
        return a;
    endfunction

    initial begin
        erm_pkg::angle_t dir [] = '{16'h0000, 16'h4000, 16'h8000, 16'hC000, 16'hFFFF,
                                    16'h2000, 16'h1FFF, 16'h2001, 16'h6000, 16'hA000,
                                    16'hE000, 16'h0001, 16'h3FFF, 16'h5555, 16'hAAAA,
                                    16'h7FFF, 16'h8001, 16'hBFFF, 16'h1234, 16'hEDCB};
        erm_pkg::in_t w;
        int  i;
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_word  = '0;
        no_idle = 1'b0;
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;
        for (i = 0; i < dir.size(); i++) begin
            w.angle_x = dir[i];
            w.angle_y = dir[(i + 7) % dir.size()];
            w.angle_z = dir[(i + 13) % dir.size()];
            send_angles(w);
        end
        for (i = 0; i < 1100; i++) begin
            no_idle = (i >= 400 && i < 600);
            w.angle_x = pick_angle();
            w.angle_y = pick_angle();
            w.angle_z = pick_angle();
            send_angles(w);
        end
        s_valid <= 1'b0;
        no_idle = 1'b0;
        while (sb.expected_q.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
        if (sb.errors == 0 && sb.expected_q.size() == 0) begin
            $display("[euler_rotation_matrix] OK");
        end else begin
            $display("[euler_rotation_matrix] ERROR");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("[euler_rotation_matrix] ERROR");
        $finish;
    end

endmodule
